>>> sv/cbfr_pkg.sv
package cbfr_pkg;

	localparam int ACC_BITS   = 48;
	localparam int FIELD_BITS = 32;
	localparam int CNT_W      = 6;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] MODE_LSB  = 2'd0;
	localparam logic [1:0] MODE_MSB  = 2'd1;
	localparam logic [1:0] MODE_WORD = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic push;
		logic merge;
		logic extract;
		logic res_zero;
		logic res_err;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_read;
		logic zero;
		logic over;
		logic need;
		logic short_bits;
		logic merge_done;
	} dp_stat_t;

	function automatic logic [ACC_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
		low_mask = {ACC_BITS{1'b1}} >> (7'(ACC_BITS) - 7'(n));
	endfunction

endpackage

>>> sv/cbfr_ram.sv
module cbfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/cbfr_dp.sv
module cbfr_dp import cbfr_pkg::*; #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_wr_data,
	input  logic                  command,
	input  logic [7:0]            byte_value,
	input  logic [CNT_W-1:0]      bit_count,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic [FIELD_BITS-1:0] field_value,
	output logic [1:0]            status
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0]    LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0]    FULL = FW'(QUEUE_DEPTH);
	localparam logic [FW-1:0]    TWO  = FW'(2);
	localparam logic [CNT_W-1:0] MAXB = CNT_W'(MAX_FIELD_BITS);

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		inc = (p == LAST) ? '0 : p + 1'b1;
	endfunction

	// committed state
	logic [1:0]          mode_q;
	logic [AW-1:0]       head_q, tail_q;
	logic [FW-1:0]       fill_q;
	logic [ACC_BITS-1:0] acc_q;
	logic [CNT_W-1:0]    held_q;

	// working copies, committed only on a successful read
	logic [AW-1:0]       whead_q;
	logic [FW-1:0]       wfill_q;
	logic [ACC_BITS-1:0] wacc_q;
	logic [CNT_W-1:0]    wheld_q;
	logic                phase_q;
	logic [7:0]          b0_q;

	logic [7:0]            byte_q;
	logic [CNT_W-1:0]      count_q;
	logic [FIELD_BITS-1:0] res_value_q, field_value_q;
	logic [1:0]            res_status_q, status_q;

	logic [1:0]          mode_eff;
	logic                word_mode;
	logic                ram_we;
	logic [7:0]          rdata;
	logic [ACC_BITS-1:0] merge_lsb, merge_msb, merge_word;
	logic [CNT_W-1:0]    rem;
	logic [ACC_BITS-1:0] val_lsb, val_msb, acc_lsb, acc_msb;

	always_comb begin
		case (mode_q)
			MODE_MSB:  mode_eff = MODE_MSB;
			MODE_WORD: mode_eff = MODE_WORD;
			default:   mode_eff = MODE_LSB;
		endcase
	end

	assign word_mode = (mode_eff == MODE_WORD);
	assign ram_we    = cmd.push && (fill_q != FULL);

	cbfr_ram #(
		.WIDTH(8),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(byte_q),
		.raddr(whead_q),
		.rdata(rdata)
	);

	assign stat.in_read    = (command == CMD_READ);
	assign stat.zero       = (count_q == '0);
	assign stat.over       = (count_q > MAXB);
	assign stat.short_bits = (wheld_q < count_q);
	assign stat.need       = (wheld_q < count_q) && (word_mode ? (wfill_q >= TWO) : (wfill_q != '0));
	assign stat.merge_done = !word_mode || phase_q;

	assign merge_lsb  = wacc_q | (ACC_BITS'(rdata) << wheld_q);
	assign merge_msb  = {wacc_q[ACC_BITS-9:0], rdata};
	assign merge_word = {wacc_q[ACC_BITS-17:0], rdata, b0_q};

	assign rem     = wheld_q - count_q;
	assign val_lsb = wacc_q & low_mask(count_q);
	assign acc_lsb = wacc_q >> count_q;
	assign val_msb = (wacc_q >> rem) & low_mask(count_q);
	assign acc_msb = wacc_q & low_mask(rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LSB;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			acc_q   <= '0;
			held_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (ram_we) begin
				tail_q <= inc(tail_q);
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.load) begin
				phase_q <= 1'b0;
			end else if (cmd.merge) begin
				phase_q <= word_mode && !phase_q;
			end
			if (cmd.extract) begin
				head_q <= whead_q;
				fill_q <= wfill_q;
				held_q <= rem;
				acc_q  <= (mode_eff == MODE_LSB) ? acc_lsb : acc_msb;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q  <= byte_value;
			count_q <= bit_count;
			whead_q <= head_q;
			wfill_q <= fill_q;
			wacc_q  <= acc_q;
			wheld_q <= held_q;
		end
		if (cmd.merge) begin
			whead_q <= inc(whead_q);
			if (word_mode && !phase_q) begin
				b0_q <= rdata;
			end else if (word_mode) begin
				wacc_q  <= merge_word;
				wheld_q <= wheld_q + CNT_W'(16);
				wfill_q <= wfill_q - TWO;
			end else begin
				wacc_q  <= (mode_eff == MODE_LSB) ? merge_lsb : merge_msb;
				wheld_q <= wheld_q + CNT_W'(8);
				wfill_q <= wfill_q - 1'b1;
			end
		end
		if (cmd.push) begin
			res_value_q  <= '0;
			res_status_q <= (fill_q == FULL) ? STATUS_FULL : STATUS_OK;
		end
		if (cmd.res_zero) begin
			res_value_q  <= '0;
			res_status_q <= STATUS_OK;
		end
		if (cmd.res_err) begin
			res_value_q  <= '0;
			res_status_q <= STATUS_SHORT;
		end
		if (cmd.extract) begin
			res_value_q  <= (mode_eff == MODE_LSB) ? val_lsb[FIELD_BITS-1:0]
			                                      : val_msb[FIELD_BITS-1:0];
			res_status_q <= STATUS_OK;
		end
		if (cmd.out_load) begin
			field_value_q <= res_value_q;
			status_q      <= res_status_q;
		end
	end

	assign field_value = field_value_q;
	assign status      = status_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("queue fill above depth");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q & ~low_mask(held_q)) == '0)
		else $error("accumulator holds bits above held count");

	a_err_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_err |=> $stable(head_q) && $stable(fill_q) && $stable(acc_q) && $stable(held_q))
		else $error("failed read changed state");

endmodule

>>> sv/cbfr_ctrl.sv
module cbfr_ctrl import cbfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_CHECK,
		S_FETCH,
		S_MERGE,
		S_EXTRACT,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.load     = in_valid && in_ready;
	assign cmd.push     = (state_q == S_PUSH);
	assign cmd.merge    = (state_q == S_MERGE);
	assign cmd.extract  = (state_q == S_EXTRACT);
	assign cmd.res_zero = (state_q == S_CHECK) && stat.zero;
	assign cmd.res_err  = (state_q == S_CHECK) && !stat.zero
	                      && (stat.over || (!stat.need && stat.short_bits));
	assign cmd.out_load = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= stat.in_read ? S_CHECK : S_PUSH;
					end
				end
				S_PUSH: begin
					state_q <= S_RESULT;
				end
				S_CHECK: begin
					if (cmd.res_zero || cmd.res_err) begin
						state_q <= S_RESULT;
					end else if (stat.need) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_EXTRACT;
					end
				end
				S_FETCH: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					// word mode takes a second byte before the unit is merged
					state_q <= stat.merge_done ? S_CHECK : S_FETCH;
				end
				S_EXTRACT: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while item in flight");

	a_merge_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> ($past(state_q) == S_FETCH))
		else $error("merge without a queue read");

	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && !out_valid_q) |=> (state_q == S_IDLE) && out_valid_q)
		else $error("result stuck with free output register");

endmodule

>>> sv/configurable_bit_field_reader.sv
// Bit field reader: push beats (command 0) store a byte in a QUEUE_DEPTH-entry byte queue;
// read beats (command 1) return bit_count bits (0..MAX_FIELD_BITS) drawn through a 48-bit
// accumulator, refilled from the queue one byte (storage_mode 0 lsb-first, 1 msb-first, 3 as 0)
// or one 16-bit little-endian word (mode 2) at a time. A read that cannot be met returns status 1
// and changes nothing; a push into a full queue is dropped with status 2. One item is in flight
// at a time. A push goes from accept through a push state to the result. A read first checks the
// held count; each queue byte then costs a registered RAM read and a merge, and each byte (modes
// 0/1) or word (mode 2) is followed by a recheck of the held count; an error or a zero-bit read goes
// from that check straight to the result. The output register frees the input side while a result
// waits. storage_mode must be written only while the block is idle; the block does not enforce it.
module configurable_bit_field_reader import cbfr_pkg::*; #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [7:0]            byte_value,
	input  logic [CNT_W-1:0]      bit_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FIELD_BITS-1:0] field_value,
	output logic [1:0]            status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cbfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cbfr_dp #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.command    (command),
		.byte_value (byte_value),
		.bit_count  (bit_count),
		.cmd        (cmd),
		.stat       (stat),
		.field_value(field_value),
		.status     (status)
	);

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cbfr_pkg::*;

	localparam logic [1:0] MODE_ALIAS  = 2'd3;	// decodes as lsb-first
	localparam int         QDEPTH      = 16;
	localparam int         MAX_BITS    = 32;
	localparam int         PHASE_BEATS = 230;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         HOLD_CYCLES = 300;
	localparam int         SETTLE      = 24;

	typedef struct packed {
		logic [FIELD_BITS-1:0] value;
		logic [1:0]            st;
	} field_result_t;

	typedef struct {
		logic            is_cfg;
		logic            cmd;
		logic [7:0]      bv;
		logic [CNT_W-1:0] cnt;
		logic            typed;
		field_result_t   res;
	} vector_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [1:0]            cfg_wr_data = MODE_LSB;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic                  command     = CMD_PUSH;
	logic [7:0]            byte_value  = 8'd0;
	logic [CNT_W-1:0]      bit_count   = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [FIELD_BITS-1:0] field_value;
	logic [1:0]            status;

	configurable_bit_field_reader #(
		.QUEUE_DEPTH(QDEPTH),
		.MAX_FIELD_BITS(MAX_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.byte_value(byte_value),
		.bit_count(bit_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.field_value(field_value),
		.status(status)
	);

	// shadow copy of the reader state
	logic [7:0]          shadow_bytes [QDEPTH];
	int                  shadow_head;
	int                  shadow_tail;
	int                  shadow_fill;
	logic [ACC_BITS-1:0] shadow_acc;
	int                  shadow_held;
	logic [1:0]          shadow_mode;

	field_result_t pending_fields [$];
	vector_t       directed_vectors [$];

	int send_idle  = 23;
	int recv_idle  = 52;
	int hold_req   = 0;
	int err_cnt    = 0;
	int beat_cnt   = 0;
	int result_cnt = 0;
	int full_cnt   = 0;
	int short_cnt  = 0;
	int cycle_cnt  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				pending_fields.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [ACC_BITS-1:0] bit_mask(input int n);
		bit_mask = (ACC_BITS'(1) << n) - ACC_BITS'(1);
	endfunction

	task automatic predict_field(input logic cmd, input logic [7:0] bv,
		input logic [CNT_W-1:0] cnt, output field_result_t res);
		logic [ACC_BITS-1:0] acc;
		logic [7:0]          b0;
		logic [7:0]          b1;
		int                  held;
		int                  head;
		int                  fill;
		int                  unit;
		int                  n;
		logic [1:0]          mode;
		begin
			res  = '0;
			n    = int'(cnt);
			mode = (shadow_mode == MODE_ALIAS) ? MODE_LSB : shadow_mode;
			if (cmd == CMD_PUSH) begin
				if (shadow_fill >= QDEPTH) begin
					res.st = STATUS_FULL;
				end else begin
					shadow_bytes[shadow_tail] = bv;
					shadow_tail = (shadow_tail + 1) % QDEPTH;
					shadow_fill++;
				end
			end else if (n > MAX_BITS) begin
				res.st = STATUS_SHORT;
			end else if (n != 0) begin
				// refill on copies, commit only when the field can be met
				acc  = shadow_acc;
				held = shadow_held;
				head = shadow_head;
				fill = shadow_fill;
				unit = (mode == MODE_WORD) ? 2 : 1;
				while (held < n && fill >= unit) begin
					b0 = shadow_bytes[head];
					head = (head + 1) % QDEPTH;
					if (mode == MODE_LSB) begin
						acc = acc | (ACC_BITS'(b0) << held);
						held += 8;
					end else if (mode == MODE_MSB) begin
						acc = (acc << 8) | ACC_BITS'(b0);
						held += 8;
					end else begin
						b1 = shadow_bytes[head];
						head = (head + 1) % QDEPTH;
						acc = (acc << 16) | (ACC_BITS'(b1) << 8) | ACC_BITS'(b0);
						held += 16;
					end
					fill -= unit;
				end
				if (held < n) begin
					res.st = STATUS_SHORT;
				end else begin
					if (mode == MODE_LSB) begin
						res.value = FIELD_BITS'(acc & bit_mask(n));
						acc = acc >> n;
						held -= n;
					end else begin
						res.value = FIELD_BITS'((acc >> (held - n)) & bit_mask(n));
						held -= n;
						acc = acc & bit_mask(held);
					end
					shadow_acc  = acc;
					shadow_held = held;
					shadow_head = head;
					shadow_fill = fill;
				end
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [FIELD_BITS-1:0] got,
		input logic [FIELD_BITS-1:0] want);
		begin
			$display("MISMATCH @%0t result %0d: %s got 0x%0h want 0x%0h", $realtime,
				result_cnt, what, got, want);
			err_cnt++;
		end
	endtask

	// result side: check each beat against the oldest expectation
	always @(posedge clk) begin
		field_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fields.size() == 0) begin
				flag_mismatch("unexpected result", {30'd0, status}, '0);
			end else begin
				want = pending_fields.pop_front();
				if (field_value !== want.value)
					flag_mismatch("field_value", field_value, want.value);
				if (status !== want.st)
					flag_mismatch("status", {30'd0, status}, {30'd0, want.st});
				if (want.st == STATUS_FULL)
					full_cnt++;
				if (want.st == STATUS_SHORT)
					short_cnt++;
			end
			result_cnt++;
		end
	end

	// receiver backpressure, with a long hold-off on request
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic send_beat(input logic cmd, input logic [7:0] bv,
		input logic [CNT_W-1:0] cnt, input logic typed, input field_result_t typed_res);
		field_result_t res;
		begin
			while ($urandom_range(0, 99) < send_idle) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid   <= 1'b1;
			command    <= cmd;
			byte_value <= bv;
			bit_count  <= cnt;
			do
				@(posedge clk);
			while (!in_ready);
			predict_field(cmd, bv, cnt, res);
			pending_fields.push_back(typed ? typed_res : res);
			beat_cnt++;
		end
	endtask

	task automatic wait_drained();
		begin
			in_valid <= 1'b0;
			while (pending_fields.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic write_mode(input logic [1:0] mode);
		begin
			wait_drained();
			repeat (SETTLE) @(posedge clk);
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= mode;
			@(posedge clk);
			cfg_wr_en   <= 1'b0;
			shadow_mode = mode;
		end
	endtask

	task automatic add_vec(input logic is_cfg, input logic cmd, input logic [7:0] bv,
		input logic [CNT_W-1:0] cnt, input logic typed, input logic [FIELD_BITS-1:0] value,
		input logic [1:0] st);
		vector_t v;
		begin
			v.is_cfg    = is_cfg;
			v.cmd       = cmd;
			v.bv        = bv;
			v.cnt       = cnt;
			v.typed     = typed;
			v.res.value = value;
			v.res.st    = st;
			directed_vectors.push_back(v);
		end
	endtask

	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (r < 5)
				pick_count = '0;
			else if (r < 40)
				pick_count = CNT_W'($urandom_range(1, 8));
			else if (r < 70)
				pick_count = CNT_W'($urandom_range(9, 16));
			else if (r < 96)
				pick_count = CNT_W'($urandom_range(17, MAX_BITS));
			else
				pick_count = CNT_W'($urandom_range(MAX_BITS + 1, 63));
		end
	endfunction

	initial begin
		logic [1:0]       phase_mode [8];
		logic             cmd;
		logic [7:0]       bv;
		logic [CNT_W-1:0] cnt;
		int               push_pct;
		int               avail;
		vector_t          v;

		phase_mode = '{MODE_LSB, MODE_MSB, MODE_WORD, MODE_ALIAS,
			MODE_WORD, MODE_MSB, MODE_LSB, MODE_WORD};

		shadow_head = 0;
		shadow_tail = 0;
		shadow_fill = 0;
		shadow_acc  = '0;
		shadow_held = 0;
		shadow_mode = MODE_LSB;
		for (int i = 0; i < QDEPTH; i++)
			shadow_bytes[i] = 8'd0;

		// after reset, lsb-first
		add_vec(0, CMD_READ, 8'h00, 6'd0,  1, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'hff, 6'd1,  1, '0, STATUS_SHORT);
		add_vec(0, CMD_READ, 8'h00, 6'd63, 1, '0, STATUS_SHORT);
		add_vec(0, CMD_READ, 8'h00, 6'd33, 1, '0, STATUS_SHORT);
		add_vec(0, CMD_PUSH, 8'hff, 6'd63, 1, '0, STATUS_OK);
		add_vec(0, CMD_PUSH, 8'h00, 6'd0,  1, '0, STATUS_OK);
		add_vec(0, CMD_PUSH, 8'ha5, 6'd0,  1, '0, STATUS_OK);
		add_vec(0, CMD_PUSH, 8'h3c, 6'd0,  1, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'h00, 6'd32, 1, 32'h3ca500ff, STATUS_OK);
		// msb-first, then a mode switch with a nibble still held
		add_vec(1, CMD_PUSH, 8'h00, 6'd0, 0, '0, MODE_MSB);
		add_vec(0, CMD_PUSH, 8'h81, 6'd0, 0, '0, STATUS_OK);
		add_vec(0, CMD_PUSH, 8'h7e, 6'd0, 0, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'h00, 6'd4,  0, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'h00, 6'd12, 0, '0, STATUS_OK);
		add_vec(0, CMD_PUSH, 8'h12, 6'd0, 0, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'h00, 6'd4, 0, '0, STATUS_OK);
		add_vec(1, CMD_PUSH, 8'h00, 6'd0, 0, '0, MODE_LSB);
		add_vec(0, CMD_READ, 8'h00, 6'd4, 0, '0, STATUS_OK);
		// word mode: a lone byte cannot be used
		add_vec(1, CMD_PUSH, 8'h00, 6'd0, 0, '0, MODE_WORD);
		add_vec(0, CMD_PUSH, 8'h34, 6'd0,  0, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'h00, 6'd8,  1, '0, STATUS_SHORT);
		add_vec(0, CMD_PUSH, 8'h12, 6'd0,  0, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'h00, 6'd16, 0, '0, STATUS_OK);
		// mode 3, short after refill must leave state alone
		add_vec(1, CMD_PUSH, 8'h00, 6'd0, 0, '0, MODE_ALIAS);
		add_vec(0, CMD_PUSH, 8'hc3, 6'd0, 0, '0, STATUS_OK);
		add_vec(0, CMD_READ, 8'h00, 6'd9, 1, '0, STATUS_SHORT);
		add_vec(0, CMD_READ, 8'h00, 6'd8, 0, '0, STATUS_OK);
		// fill the queue, then one push too many
		for (int i = 0; i < QDEPTH; i++)
			add_vec(0, CMD_PUSH, 8'(8'h5a ^ i), 6'd0, 0, '0, STATUS_OK);
		add_vec(0, CMD_PUSH, 8'hff, 6'd0, 1, '0, STATUS_FULL);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_vectors[i]) begin
			v = directed_vectors[i];
			if (v.is_cfg)
				write_mode(v.res.st);
			else
				send_beat(v.cmd, v.bv, v.cnt, v.typed, v.res);
		end

		for (int p = 0; p < 8; p++) begin
			write_mode(phase_mode[p]);
			if (p < 3) begin
				send_idle = 23;
				recv_idle = 52;
			end else if (p < 6) begin
				send_idle = 52;
				recv_idle = 23;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if ((p == 1 || p == 6) && k == 60)
					hold_req++;
				if ((p == 4 || p == 7) && k == 120)
					wait_drained();
				avail = shadow_held + 8 * shadow_fill;
				if (shadow_fill >= QDEPTH - 2)
					push_pct = 15;
				else if (avail < MAX_BITS)
					push_pct = 70;
				else
					push_pct = 45;
				bv = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 99) < 5) begin
					// noise: any command, any count
					cmd = 1'($urandom_range(0, 1));
					cnt = CNT_W'($urandom_range(0, 63));
				end else if ($urandom_range(0, 99) < push_pct) begin
					cmd = CMD_PUSH;
					cnt = CNT_W'($urandom_range(0, 63));
				end else begin
					cmd = CMD_READ;
					cnt = pick_count();
				end
				send_beat(cmd, bv, cnt, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("%0d beats sent over modes 0..3 and three backpressure profiles", beat_cnt);
		$display("%0d results checked (%0d full drops, %0d short reads), %0d errors",
			result_cnt, full_cnt, short_cnt, err_cnt);
		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
